### src/tbgmc_pkg.sv
// Shared types, constants and the gesture decode function of the gesture mode controller.
`default_nettype none

package tbgmc_pkg;

	localparam int TIMER_BITS = 10;
	localparam int NUM_BTN    = 3;
	localparam int CNT_W      = 3;
	localparam int CFG_DATA_W = 10;
	localparam int CFG_IDX_W  = 3;
	localparam int BTN_W      = 2;

	localparam logic [CNT_W-1:0]      CNT_MAX     = CNT_W'(7);
	localparam logic [TIMER_BITS-1:0] GAP_RESET   = TIMER_BITS'(15);
	localparam logic [TIMER_BITS-1:0] HOLD_RESET  = TIMER_BITS'(200);
	localparam logic [TIMER_BITS-1:0] FIRST_RESET = TIMER_BITS'(300);
	localparam logic [TIMER_BITS-1:0] REP0_RESET  = TIMER_BITS'(300);
	localparam logic [TIMER_BITS-1:0] REP1_RESET  = TIMER_BITS'(20);

	localparam logic [BTN_W-1:0] BTN_ZERO = BTN_W'(0);
	localparam logic [BTN_W-1:0] BTN_ONE  = BTN_W'(1);

	typedef enum logic [1:0] {
		MODE_INIT   = 2'd0,
		MODE_NORMAL = 2'd1,
		MODE_MANUAL = 2'd2,
		MODE_TUNING = 2'd3
	} mode_t;

	typedef enum logic [3:0] {
		ACT_NONE         = 4'd0,
		ACT_NO_EFFECT    = 4'd1,
		ACT_BEGIN_NORMAL = 4'd2,
		ACT_RUN_MANUAL   = 4'd3,
		ACT_RUN_TUNING   = 4'd4,
		ACT_MODIFY       = 4'd5,
		ACT_SAVE         = 4'd6,
		ACT_ENTER_MANUAL = 4'd7,
		ACT_ENTER_TUNING = 4'd8,
		ACT_WALK_NORMAL  = 4'd9,
		ACT_WALK_MANUAL  = 4'd10,
		ACT_ALL_OFF      = 4'd11
	} act_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PRESSED_LEVEL = 3'd0,
		CFG_RELEASE_GAP   = 3'd1,
		CFG_HOLD_FIRST    = 3'd2,
		CFG_REPEAT_ZERO   = 3'd3,
		CFG_REPEAT_ONE    = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic                  pressed_level;
		logic [TIMER_BITS-1:0] gap_load;
		logic [TIMER_BITS-1:0] hold_load;
		logic [TIMER_BITS-1:0] repeat_zero;
		logic [TIMER_BITS-1:0] repeat_one;
	} cfg_t;

	typedef struct packed {
		logic [NUM_BTN-1:0][1:0]            hist;
		logic [NUM_BTN-1:0]                 stable;
		logic [NUM_BTN-1:0][CNT_W-1:0]      pcnt;
		logic [NUM_BTN-1:0][CNT_W-1:0]      rcnt;
		logic [NUM_BTN-1:0][TIMER_BITS-1:0] gap;
		logic [NUM_BTN-1:0][TIMER_BITS-1:0] hold;
		mode_t                              mode;
	} gest_state_t;

	typedef struct packed {
		act_t [NUM_BTN-1:0] act;
		mode_t              mode;
	} result_t;

	typedef struct packed {
		act_t  act;
		mode_t mode;
	} fire_t;

	// Sorts the counts of a firing button into an action and the new mode.
	function automatic fire_t fire_decode(input logic [BTN_W-1:0] btn,
		input logic [CNT_W-1:0] p, input logic [CNT_W-1:0] r, input mode_t m);
		fire_t f;
		logic  tap;
		logic  single;
		logic  dbl;
		logic  triple;
		f.act  = ACT_NO_EFFECT;
		f.mode = m;
		tap    = (p == CNT_W'(0) || p == CNT_W'(1)) && r == CNT_W'(0);
		single = p == CNT_W'(1) && r == CNT_W'(1);
		dbl    = p == CNT_W'(2) && (r == CNT_W'(1) || r == CNT_W'(2));
		triple = p == CNT_W'(3) && (r == CNT_W'(2) || r == CNT_W'(3));
		if (btn == BTN_ZERO) begin
			if (tap) begin
				if (m == MODE_MANUAL) f.act = ACT_RUN_MANUAL;
				else if (m == MODE_TUNING) f.act = ACT_RUN_TUNING;
			end else if (single) begin
				f.mode = MODE_NORMAL;
				f.act  = ACT_BEGIN_NORMAL;
			end else if (dbl) begin
				f.mode = MODE_MANUAL;
				f.act  = ACT_ENTER_MANUAL;
			end else if (triple) begin
				f.mode = MODE_TUNING;
				f.act  = ACT_ENTER_TUNING;
			end
		end else if (btn == BTN_ONE) begin
			if (tap) begin
				if (m == MODE_TUNING) f.act = ACT_MODIFY;
			end else if (single) begin
				if (m == MODE_NORMAL) f.act = ACT_BEGIN_NORMAL;
				else if (m == MODE_MANUAL) f.act = ACT_RUN_MANUAL;
				else if (m == MODE_TUNING) f.act = ACT_MODIFY;
			end else if (dbl) begin
				if (m == MODE_TUNING) f.act = ACT_SAVE;
			end
		end else begin
			if (single) begin
				if (m == MODE_NORMAL) f.act = ACT_WALK_NORMAL;
				else if (m == MODE_MANUAL) f.act = ACT_WALK_MANUAL;
			end else if (dbl) begin
				f.mode = MODE_INIT;
				f.act  = ACT_ALL_OFF;
			end
		end
		return f;
	endfunction

endpackage

`default_nettype wire

### src/tbgmc_if.sv
// Handshake channels for tick items and result items of the gesture mode controller.
`default_nettype none

interface tbgmc_in_if;
	logic valid;
	logic ready;
	logic level_zero;
	logic level_one;
	logic level_two;

	modport source (output valid, output level_zero, output level_one, output level_two,
		input ready);
	modport sink (input valid, input level_zero, input level_one, input level_two,
		output ready);
endinterface

interface tbgmc_out_if;
	import tbgmc_pkg::*;
	logic       valid;
	logic       ready;
	logic [3:0] action_zero;
	logic [3:0] action_one;
	logic [3:0] action_two;
	logic [1:0] mode_now;

	modport source (output valid, output action_zero, output action_one,
		output action_two, output mode_now, input ready);
	modport sink (input valid, input action_zero, input action_one,
		input action_two, input mode_now, output ready);
endinterface

`default_nettype wire

### src/three_button_gesture_mode_controller.sv
// Top level of the three-button gesture mode controller.
`default_nettype none

// Each item is one tick of raw levels for three buttons; the block debounces them over three
// samples, counts clicks, runs the release-gap and hold timers, and returns one result item per
// tick with an action code for each button and the mode after the tick. It takes one item per
// clock cycle while the result channel is not stalled; an accepted item waits in the input
// register while the gesture logic works on it, and its result item goes into the result register
// once that is empty or being taken, and is offered from there. While a result waits, the block
// takes one more item into an empty input register and then holds off until the result is taken.
module three_button_gesture_mode_controller (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_wr_en,
	input  wire logic [tbgmc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [tbgmc_pkg::CFG_DATA_W-1:0] cfg_data,
	tbgmc_in_if.sink                              tick_in,
	tbgmc_out_if.source                           result_out
);
	import tbgmc_pkg::*;

	cfg_t               cfg;
	gest_state_t        state_q;
	gest_state_t        state_nxt;
	result_t            res;
	result_t            res_q;
	logic               valid_s1;
	logic [NUM_BTN-1:0] levels_s1;
	logic               out_valid_q;
	logic               advance;
	logic               accept;
	logic               load;

	tbgmc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	tbgmc_core u_core (
		.levels (levels_s1),
		.cfg    (cfg),
		.cur    (state_q),
		.nxt    (state_nxt),
		.res    (res)
	);

	assign advance       = !out_valid_q || result_out.ready;
	assign tick_in.ready = !valid_s1 || advance;
	assign accept        = tick_in.valid && tick_in.ready;
	assign load          = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			state_q.hist   <= '0;
			state_q.stable <= '0;
			state_q.pcnt   <= '0;
			state_q.rcnt   <= '0;
			state_q.gap    <= '0;
			state_q.hold   <= {NUM_BTN{HOLD_RESET}};
			state_q.mode   <= MODE_INIT;
		end else begin
			if (accept) valid_s1 <= 1'b1;
			else if (load) valid_s1 <= 1'b0;
			if (load) out_valid_q <= 1'b1;
			else if (result_out.ready) out_valid_q <= 1'b0;
			if (load) state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) levels_s1 <= {tick_in.level_two, tick_in.level_one, tick_in.level_zero};
		if (load) res_q <= res;
	end

	assign result_out.valid       = out_valid_q;
	assign result_out.action_zero = res_q.act[0];
	assign result_out.action_one  = res_q.act[1];
	assign result_out.action_two  = res_q.act[2];
	assign result_out.mode_now    = res_q.mode;

	a_load_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> out_valid_q)
		else $error("result register not valid after a tick was processed");

	a_mode_held: assert property (@(posedge clk) disable iff (!arst_n)
		!load |=> $stable(state_q.mode))
		else $error("mode changed without a processed tick");

	a_all_off_mode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.act[2] == ACT_ALL_OFF |-> res_q.mode == MODE_INIT)
		else $error("all-off action without init mode");

endmodule

`default_nettype wire

### src/tbgmc_cfg_regs.sv
// Configuration registers of the gesture mode controller.
`default_nettype none

module tbgmc_cfg_regs (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_wr_en,
	input  wire logic [tbgmc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [tbgmc_pkg::CFG_DATA_W-1:0] cfg_data,
	output tbgmc_pkg::cfg_t                       cfg
);
	import tbgmc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pressed_level <= 1'b0;
			cfg_q.gap_load      <= GAP_RESET;
			cfg_q.hold_load     <= FIRST_RESET;
			cfg_q.repeat_zero   <= REP0_RESET;
			cfg_q.repeat_one    <= REP1_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_idx_t'(cfg_index))
				CFG_PRESSED_LEVEL: cfg_q.pressed_level <= cfg_data[0];
				CFG_RELEASE_GAP:   cfg_q.gap_load      <= TIMER_BITS'(cfg_data);
				CFG_HOLD_FIRST:    cfg_q.hold_load     <= TIMER_BITS'(cfg_data);
				CFG_REPEAT_ZERO:   cfg_q.repeat_zero   <= TIMER_BITS'(cfg_data);
				CFG_REPEAT_ONE:    cfg_q.repeat_one    <= TIMER_BITS'(cfg_data);
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

### src/tbgmc_core.sv
// Per-tick debounce, click counting, timers, firing and mode decode for all three buttons.
`default_nettype none

module tbgmc_core (
	input  wire logic [tbgmc_pkg::NUM_BTN-1:0] levels,
	input  wire tbgmc_pkg::cfg_t                cfg,
	input  wire tbgmc_pkg::gest_state_t         cur,
	output tbgmc_pkg::gest_state_t              nxt,
	output tbgmc_pkg::result_t                  res
);
	import tbgmc_pkg::*;

	always_comb begin
		gest_state_t      st;
		logic [2:0]       h;
		logic             s;
		logic             fire_now;
		fire_t            fr;
		logic [BTN_W-1:0] bi;
		st = cur;
		for (int k = 0; k < NUM_BTN; k++) begin
			res.act[k] = ACT_NONE;
		end
		// Buttons are handled in order; a firing clears the counts seen by later buttons.
		for (int b = 0; b < NUM_BTN; b++) begin
			bi       = BTN_W'(b);
			s        = levels[bi] == cfg.pressed_level;
			h        = {st.hist[bi], s};
			st.hist[bi] = h[1:0];
			fire_now = 1'b0;
			if (h == 3'b000 || h == 3'b111) begin
				if (st.stable[bi] != s) begin
					st.stable[bi] = s;
					if (!s) begin
						if (st.rcnt[bi] != CNT_MAX) st.rcnt[bi] = st.rcnt[bi] + CNT_W'(1);
						st.gap[bi] = cfg.gap_load;
					end else begin
						if (st.pcnt[bi] != CNT_MAX) st.pcnt[bi] = st.pcnt[bi] + CNT_W'(1);
						st.hold[bi] = cfg.hold_load;
					end
				end else if (!s) begin
					if (st.gap[bi] != '0) begin
						st.gap[bi] = st.gap[bi] - TIMER_BITS'(1);
						fire_now   = st.gap[bi] == '0;
					end
				end else begin
					if (st.hold[bi] != '0) begin
						st.hold[bi] = st.hold[bi] - TIMER_BITS'(1);
						if (st.hold[bi] == '0) begin
							fire_now = 1'b1;
							if (bi == BTN_ZERO) st.hold[bi] = cfg.repeat_zero;
							else if (bi == BTN_ONE) st.hold[bi] = cfg.repeat_one;
						end
					end
				end
			end
			fr = fire_decode(bi, st.pcnt[bi], st.rcnt[bi], st.mode);
			if (fire_now) begin
				res.act[bi] = fr.act;
				st.mode     = fr.mode;
				st.pcnt     = '0;
				st.rcnt     = '0;
				st.gap      = '0;
			end
		end
		nxt      = st;
		res.mode = st.mode;
	end

endmodule

`default_nettype wire
